>>> sv/ilir_pkg.sv
// Package with opcodes, status codes, sizes and cell control types of the indexed list.
`timescale 1ns / 1ps
`default_nettype none
package ilir_pkg;

    localparam int CAPACITY = 64;

    localparam int OPCODE_W = 3;
    localparam int POS_W    = 8;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OPCODE_W-1:0] OP_APPEND = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_READ   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_REMOVE = 1'b1
    } cell_mode_t;

    typedef struct packed {
        logic       en;
        cell_mode_t mode;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> sv/ilir_cell.sv
// One list cell: holds one entry, loads, shifts from a neighbor and drives the read bus.
`timescale 1ns / 1ps
`default_nettype none
module ilir_cell #(
    parameter int SLOT_W = 6,
    parameter int INDEX  = 0
) (
    input  wire logic                           aclk,
    input  wire ilir_pkg::cell_ctrl_t           ctrl,
    input  wire logic [SLOT_W-1:0]              slot,
    input  wire logic [ilir_pkg::VALUE_W-1:0]   load_value,
    input  wire logic [ilir_pkg::VALUE_W-1:0]   left_entry,
    input  wire logic [ilir_pkg::VALUE_W-1:0]   right_entry,
    output logic      [ilir_pkg::VALUE_W-1:0]   entry,
    output logic      [ilir_pkg::VALUE_W-1:0]   read_out
);

    localparam logic [SLOT_W-1:0] IDX = SLOT_W'(INDEX);

    logic [ilir_pkg::VALUE_W-1:0] entry_reg;
    logic [ilir_pkg::VALUE_W-1:0] entry_next;
    logic                         at_slot;
    logic                         above_slot;

    assign at_slot    = (slot == IDX);
    assign above_slot = (IDX > slot);

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.en) begin
            if (ctrl.mode == ilir_pkg::MODE_INSERT) begin
                if (at_slot) begin
                    entry_next = load_value;
                end else if (above_slot) begin
                    entry_next = left_entry;
                end
            end else begin
                if (at_slot || above_slot) begin
                    entry_next = right_entry;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry    = entry_reg;
    assign read_out = at_slot ? entry_reg : '0;

endmodule
`default_nettype wire

>>> sv/indexed_list_insert_remove.sv
// Latency: the result of an item is valid in the cycle after the item is accepted.
// Throughput: one item per cycle unless m_ready stalls; the whole row of cells shifts in
// the accept cycle, and a result register parts the input side from the result side.
// Reset: aresetn clears the entry count and the result valid flag; the entries
// themselves are left undefined and are only read below the count.
`timescale 1ns / 1ps
`default_nettype none
module indexed_list_insert_remove #(
    parameter int CAPACITY = ilir_pkg::CAPACITY
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [ilir_pkg::OPCODE_W-1:0]     s_opcode,
    input  wire logic signed [ilir_pkg::POS_W-1:0] s_position,
    input  wire logic [ilir_pkg::VALUE_W-1:0]      s_item_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [ilir_pkg::VALUE_W-1:0]      m_read_value,
    output logic      [ilir_pkg::STATUS_W-1:0]     m_status,
    output logic      [ilir_pkg::COUNT_W-1:0]      m_entry_count
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int IW     = ((CNT_W > ilir_pkg::POS_W) ? CNT_W : ilir_pkg::POS_W) + 2;
    localparam logic [IW-1:0] CAP_I = IW'(CAPACITY);

    logic [CNT_W-1:0]                  count_reg;
    logic [CNT_W-1:0]                  count_next;
    logic                              m_valid_reg;
    logic [ilir_pkg::VALUE_W-1:0]      read_value_reg;
    logic [ilir_pkg::VALUE_W-1:0]      read_value_next;
    logic [ilir_pkg::STATUS_W-1:0]     status_reg;
    logic [ilir_pkg::STATUS_W-1:0]     status_next;
    logic [ilir_pkg::COUNT_W-1:0]      entry_count_reg;

    logic                              accept;
    logic [IW-1:0]                     cnt_ext;
    logic [IW-1:0]                     pos_ext;
    logic [IW-1:0]                     rel_idx;
    logic                              rel_ok;
    logic                              ins_ok;
    logic                              full;
    logic [SLOT_W-1:0]                 slot;
    ilir_pkg::cell_ctrl_t              ctrl;
    logic [ilir_pkg::VALUE_W-1:0]      read_bus;
    logic [CNT_W+ilir_pkg::COUNT_W-1:0] count_wide;

    logic [ilir_pkg::VALUE_W-1:0] entry_q  [CAPACITY];
    logic [ilir_pkg::VALUE_W-1:0] read_q   [CAPACITY];

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign cnt_ext = IW'(count_reg);
    assign pos_ext = {{(IW - ilir_pkg::POS_W){s_position[ilir_pkg::POS_W-1]}}, s_position};
    assign rel_idx = s_position[ilir_pkg::POS_W-1] ? (cnt_ext + pos_ext) : pos_ext;
    assign rel_ok  = !rel_idx[IW-1] && (rel_idx < cnt_ext);
    assign ins_ok  = !s_position[ilir_pkg::POS_W-1] && (pos_ext <= cnt_ext);
    assign full    = (cnt_ext >= CAP_I);

    always_comb begin
        read_bus = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            read_bus = read_bus | read_q[i];
        end
    end

    always_comb begin
        ctrl.en         = 1'b0;
        ctrl.mode       = ilir_pkg::MODE_INSERT;
        slot            = rel_idx[SLOT_W-1:0];
        count_next      = count_reg;
        status_next     = ilir_pkg::ST_OK;
        read_value_next = '0;
        unique case (s_opcode)
            ilir_pkg::OP_APPEND: begin
                slot = count_reg[SLOT_W-1:0];
                if (full) begin
                    status_next = ilir_pkg::ST_FULL;
                end else begin
                    ctrl.en    = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            ilir_pkg::OP_INSERT: begin
                slot = pos_ext[SLOT_W-1:0];
                if (!ins_ok) begin
                    status_next = ilir_pkg::ST_RANGE;
                end else if (full) begin
                    status_next = ilir_pkg::ST_FULL;
                end else begin
                    ctrl.en    = accept;
                    count_next = count_reg + 1'b1;
                end
            end
            ilir_pkg::OP_REMOVE: begin
                ctrl.mode = ilir_pkg::MODE_REMOVE;
                if (!rel_ok) begin
                    status_next = ilir_pkg::ST_RANGE;
                end else begin
                    ctrl.en         = accept;
                    count_next      = count_reg - 1'b1;
                    read_value_next = read_bus;
                end
            end
            ilir_pkg::OP_READ: begin
                if (!rel_ok) begin
                    status_next = ilir_pkg::ST_RANGE;
                end else begin
                    read_value_next = read_bus;
                end
            end
            ilir_pkg::OP_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ilir_pkg::VALUE_W-1:0] left_entry;
            logic [ilir_pkg::VALUE_W-1:0] right_entry;
            if (g == 0) begin : g_first
                assign left_entry = s_item_value;
            end else begin : g_inner_l
                assign left_entry = entry_q[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_entry = entry_q[g];
            end else begin : g_inner_r
                assign right_entry = entry_q[g+1];
            end
            ilir_cell #(
                .SLOT_W(SLOT_W),
                .INDEX (g)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .slot       (slot),
                .load_value (s_item_value),
                .left_entry (left_entry),
                .right_entry(right_entry),
                .entry      (entry_q[g]),
                .read_out   (read_q[g])
            );
        end
    endgenerate

    assign count_wide = {{ilir_pkg::COUNT_W{1'b0}}, count_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            read_value_reg  <= read_value_next;
            status_reg      <= status_next;
            entry_count_reg <= count_wide[ilir_pkg::COUNT_W-1:0];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = read_value_reg;
    assign m_status      = status_reg;
    assign m_entry_count = entry_count_reg;

endmodule
`default_nettype wire
